@@ rtl/dht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_pkg
// Types and codes shared by the double hashing table block.
// ----------------------------------------------------------------------------
package dht_pkg;

   // Field widths fixed by the interface.
   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 31;
   localparam int SLOT_W   = 10;
   localparam int STATE_W  = 2;
   localparam int TS_W     = 11;
   localparam int SP_W     = 10;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_PRIME = 1'b1;

   // Configuration reset values.
   localparam logic [TS_W-1:0] TABLE_SIZE_RESET   = 11'd1021;
   localparam logic [SP_W-1:0] SECOND_PRIME_RESET = 10'd7;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

   // Slot states.
   localparam logic [STATE_W-1:0] SLOT_EMPTY    = 2'd0;
   localparam logic [STATE_W-1:0] SLOT_OCCUPIED = 2'd1;
   localparam logic [STATE_W-1:0] SLOT_DELETED  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [SLOT_W-1:0]  slot;
      logic [STATE_W-1:0] slot_state;
   } rsp_type;

   // One word of slot memory: state and stored key.
   typedef struct packed {
      logic [STATE_W-1:0] status;
      logic [KEY_W-1:0]   key;
   } entry_type;

endpackage
`default_nettype wire

@@ rtl/double_hash_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double hashing table
// Open-addressing hash set with double hashing and tombstones in slot memory.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. After acceptance the two hashes are
// reduced by bit-serial remainder units (one step per key bit for key mod
// table_size and key mod second_prime in parallel, with a registered done),
// then the step is reduced mod table_size by a third such unit. The home slot
// is read once that reduction is done. The walk then makes one probe per
// cycle, for 1 to n_eff probes (the clamped table size), and the result is
// registered and then moved into the output register once that register no
// longer holds a stalled response. The next request is taken from the
// cycle after the result has been handed to the output register. After reset
// a clearing pass writes every slot empty, during which no request is
// accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module double_hash_table_top #(
   parameter int DEPTH = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire dht_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output dht_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_we,
   input  wire [dht_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [dht_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int ENT_W = $bits(dht_pkg::entry_type);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_HASH  = 6'b000100,
      S_STEP  = 6'b001000,
      S_PROBE = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [dht_pkg::TS_W-1:0]   table_size_ff;
   logic [dht_pkg::SP_W-1:0]   second_prime_ff;
   logic [dht_pkg::TS_W-1:0]   n_eff;
   logic [dht_pkg::SP_W-1:0]   p_eff;

   logic [dht_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [dht_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]           cur_ff, cur_in;
   logic [dht_pkg::TS_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]           clr_ff, clr_in;
   dht_pkg::rsp_type           res_ff, res_in;
   dht_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       req_fire;
   logic                       done_a, done_b, done_c;
   logic [dht_pkg::TS_W-1:0]   rem_a, rem_c;
   logic [dht_pkg::SP_W-1:0]   rem_b;
   logic [dht_pkg::SP_W-1:0]   step_raw;
   logic [IDX_W:0]             sum;
   logic [IDX_W:0]             n_wide;
   logic [IDX_W-1:0]           nxt_idx;

   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;
   dht_pkg::entry_type         mem_wdata;
   logic [IDX_W-1:0]           mem_raddr;
   dht_pkg::entry_type         mem_rdata;
   logic [ENT_W-1:0]           mem_rdata_raw;

   logic                       key_match;
   logic                       hit;
   logic                       stop;
   logic                       last;
   logic                       out_free;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff   <= dht_pkg::TABLE_SIZE_RESET;
         second_prime_ff <= dht_pkg::SECOND_PRIME_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dht_pkg::CSR_TABLE_SIZE:   table_size_ff   <= csr_wdata[dht_pkg::TS_W-1:0];
            dht_pkg::CSR_SECOND_PRIME: second_prime_ff <= csr_wdata[dht_pkg::SP_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective table size (clamped to two and to the depth) and prime.
   always_comb begin
      if (table_size_ff < dht_pkg::TS_W'(2)) begin
         n_eff = dht_pkg::TS_W'(2);
      end else if (32'(table_size_ff) > DEPTH) begin
         n_eff = dht_pkg::TS_W'(DEPTH);
      end else begin
         n_eff = table_size_ff;
      end
      p_eff = (second_prime_ff == '0) ? dht_pkg::SP_W'(1) : second_prime_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Hash units: home slot, key mod prime, and step reduced mod table size.
   dht_mod #(
      .NUM_W(dht_pkg::KEY_W),
      .DEN_W(dht_pkg::TS_W)
   ) u_mod_home (
      .clock(clock),
      .reset(reset),
      .start(req_fire),
      .num  (req_data.key),
      .den  (n_eff),
      .done (done_a),
      .rem  (rem_a)
   );

   dht_mod #(
      .NUM_W(dht_pkg::KEY_W),
      .DEN_W(dht_pkg::SP_W)
   ) u_mod_prime (
      .clock(clock),
      .reset(reset),
      .start(req_fire),
      .num  (req_data.key),
      .den  (p_eff),
      .done (done_b),
      .rem  (rem_b)
   );

   assign step_raw = p_eff - rem_b;

   dht_mod #(
      .NUM_W(dht_pkg::SP_W),
      .DEN_W(dht_pkg::TS_W)
   ) u_mod_step (
      .clock(clock),
      .reset(reset),
      .start((state_ff == S_HASH) && done_b),
      .num  (step_raw),
      .den  (n_eff),
      .done (done_c),
      .rem  (rem_c)
   );

   // Next probe slot: add the reduced step and wrap once at the table size.
   assign n_wide = (IDX_W + 1)'(n_eff);
   assign sum    = {1'b0, cur_ff} + (IDX_W + 1)'(rem_c);
   assign nxt_idx = (sum >= n_wide) ? IDX_W'(sum - n_wide) : IDX_W'(sum);

   // Slot memory: state and key of every slot.
   dht_ram #(
      .WIDTH(ENT_W),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata_raw)
   );

   assign mem_rdata = dht_pkg::entry_type'(mem_rdata_raw);

   // Probe decision on the slot read in the previous cycle.
   assign key_match = (mem_rdata.key == key_ff);
   assign hit       = (mem_rdata.status == dht_pkg::SLOT_OCCUPIED) && key_match;
   assign stop      = (mem_rdata.status != dht_pkg::SLOT_OCCUPIED) || key_match;
   assign last      = (cnt_ff == n_eff - 1'b1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = '{status: dht_pkg::SLOT_OCCUPIED, key: key_ff};
      mem_raddr    = nxt_idx;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '{status: dht_pkg::SLOT_EMPTY, key: '0};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               func_in  = req_data.func;
               key_in   = req_data.key;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (done_b) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            // Start the walk: read the home slot.
            mem_raddr = IDX_W'(rem_a);
            if (done_c) begin
               cur_in   = IDX_W'(rem_a);
               cnt_in   = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (stop || last) begin
               res_in.slot       = dht_pkg::SLOT_W'(cur_ff);
               res_in.slot_state = mem_rdata.status;
               case (func_ff)
                  dht_pkg::FUNC_INSERT: begin
                     res_in.ok = (mem_rdata.status != dht_pkg::SLOT_OCCUPIED);
                     mem_we    = res_in.ok;
                  end
                  dht_pkg::FUNC_DELETE: begin
                     res_in.ok = hit;
                     mem_we    = hit;
                     mem_wdata = '{status: dht_pkg::SLOT_DELETED, key: mem_rdata.key};
                  end
                  default: begin
                     res_in.ok = hit;
                  end
               endcase
               state_in = S_OUT;
            end else begin
               cur_in = nxt_idx;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Assertions.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_hash_units_aligned: assert property (@(posedge clock) disable iff (reset)
      done_a == done_b)
      else $error("hash units finished out of step");

   a_write_in_place: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR) || (state_ff == S_PROBE))
      else $error("slot memory written outside clearing or probe end");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (cnt_ff < n_eff))
      else $error("probe count ran past the table size");

endmodule
`default_nettype wire

@@ rtl/dht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/dht_mod.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_mod
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dht_mod #(
   parameter int NUM_W = 31,
   parameter int DEN_W = 11
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire [NUM_W-1:0]   num,
   input  wire [DEN_W-1:0]   den,
   output logic              done,
   output logic [DEN_W-1:0]  rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;

   // One restoring step: bring in the next dividend bit and subtract if it fits.
   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff, num_ff[NUM_W-1]};
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(shifted - {1'b0, den_ff});
         end else begin
            rem_in = DEN_W'(shifted);
         end
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

@@ tb/tb_double_hash_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double hashing table testbench
// Drives find, insert, delete and unknown-function transactions into the hash table under a
// range of table sizes and step primes. A scoreboard keeps its own copy of
// the slot memory, predicts each response and checks it field by field.
// ----------------------------------------------------------------------------
import dht_pkg::*;

class dht_scoreboard;
   localparam int SLOTS = 1024;

   logic [STATE_W-1:0] status [SLOTS];
   logic [KEY_W-1:0]   keys [SLOTS];
   logic [TS_W-1:0]    table_size;
   logic [SP_W-1:0]    second_prime;
   rsp_type            pending[$];
   int                 errors;

   function new();
      foreach (status[i]) begin
         status[i] = SLOT_EMPTY;
         keys[i]   = '0;
      end
      table_size   = TABLE_SIZE_RESET;
      second_prime = SECOND_PRIME_RESET;
      errors       = 0;
   endfunction

   // Mirror a register write so later predictions use the new setting.
   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      if (idx == CSR_TABLE_SIZE) begin
         table_size = value[TS_W-1:0];
      end else begin
         second_prime = value[SP_W-1:0];
      end
   endfunction

   // Walk the probe sequence for an accepted transaction, update the slot
   // copy and queue the response it must produce.
   function void note_request(req_type r);
      int unsigned        n;
      int unsigned        p;
      int unsigned        home;
      int unsigned        stride;
      int unsigned        idx;
      logic [STATE_W-1:0] prior;
      logic               hit;
      rsp_type            want;
      n = table_size;
      if (n < 2) n = 2;
      if (n > SLOTS) n = SLOTS;
      p = (second_prime == 0) ? 1 : second_prime;
      home = r.key % n;
      stride = p - (r.key % p);
      idx = 0;
      for (int unsigned i = 0; i < n; i++) begin
         idx = (home + i * stride) % n;
         if (status[idx] != SLOT_OCCUPIED || keys[idx] == r.key) break;
      end
      prior = status[idx];
      hit = (prior == SLOT_OCCUPIED) && (keys[idx] == r.key);
      want.ok = 1'b0;
      case (r.func)
         FUNC_INSERT: begin
            if (prior != SLOT_OCCUPIED) begin
               status[idx] = SLOT_OCCUPIED;
               keys[idx]   = r.key;
               want.ok     = 1'b1;
            end
         end
         FUNC_DELETE: begin
            if (hit) begin
               status[idx] = SLOT_DELETED;
               want.ok     = 1'b1;
            end
         end
         default: begin
            want.ok = hit;
         end
      endcase
      want.slot       = idx[SLOT_W-1:0];
      want.slot_state = prior;
      pending.push_back(want);
   endfunction

   task log_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Compare one accepted response with the oldest expectation.
   task check_response(rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         log_mismatch("response with no transaction outstanding");
         return;
      end
      want = pending.pop_front();
      if (got.ok !== want.ok)
         log_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
      if (got.slot !== want.slot)
         log_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
      if (got.slot_state !== want.slot_state)
         log_mismatch($sformatf("slot_state %0d, expected %0d",
                                got.slot_state, want.slot_state));
   endtask
endclass

module tb_double_hash_table_top;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   bit                   calm = 1'b0;
   int unsigned          cycles = 0;
   dht_scoreboard        board;

   double_hash_table_top #(
      .DEPTH(1024)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Guard against a hung block.
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("double_hash_table_top verification failed");
         $finish;
      end
   end

   // Every response transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // Response side: ready, broken by stall bursts until the quiet final phase.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Present one transaction, possibly after an idle burst, and hold it until
   // it is taken. Returns at the falling edge after acceptance.
   task automatic issue(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
      req_type item;
      item.func = f;
      item.key  = k;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
      @(negedge clock);
   endtask

   // Stop sending and wait until every outstanding response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.write_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_table(input logic [CSR_W-1:0] ts, input logic [CSR_W-1:0] sp);
      write_reg(CSR_TABLE_SIZE, ts);
      write_reg(CSR_SECOND_PRIME, sp);
   endtask

   // One random phase: a fresh setting and a small key pool, so that finds
   // and deletes hit keys that were inserted and probe chains collide.
   task automatic run_phase(input logic [CSR_W-1:0] ts, input logic [CSR_W-1:0] sp,
                            input int count);
      logic [KEY_W-1:0]  pool[$];
      int unsigned       n;
      int unsigned       anchor;
      int unsigned       pick;
      logic [KEY_W-1:0]  k;
      logic [FUNC_W-1:0] f;
      settle();
      set_table(ts, sp);
      n = (ts < 2) ? 2 : ((ts > 1024) ? 1024 : ts);
      anchor = $urandom_range(0, n - 1);
      repeat ($urandom_range(6, 24)) begin
         case ($urandom_range(0, 2))
            0:       pool.push_back(KEY_W'($urandom()));
            1:       pool.push_back(KEY_W'($urandom_range(0, 3 * n)));
            default: pool.push_back(KEY_W'(anchor + n * $urandom_range(0, 1 << 20)));
         endcase
      end
      for (int j = 0; j < count; j++) begin
         // Now and then let the table drain completely before going on.
         if ($urandom_range(0, 79) == 0) settle();
         pick = $urandom_range(0, 19);
         if (pick < 8) f = FUNC_INSERT;
         else if (pick < 14) f = FUNC_FIND;
         else if (pick < 19) f = FUNC_DELETE;
         else f = FUNC_UNKNOWN;
         if ($urandom_range(0, 4) == 0) k = KEY_W'($urandom());
         else k = pool[$urandom_range(0, pool.size() - 1)];
         issue(f, k);
      end
   endtask

   initial begin
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Seven slots, step prime five: hits, misses, repeated insert, tombstone
      // reuse that leaves a duplicate, extreme keys and the unknown function.
      set_table(11'd7, 11'd5);
      issue(FUNC_FIND, 31'd0);
      issue(FUNC_INSERT, 31'd0);
      issue(FUNC_INSERT, 31'd0);
      issue(FUNC_FIND, 31'd0);
      issue(FUNC_INSERT, 31'd3);
      issue(FUNC_INSERT, 31'd10);
      issue(FUNC_DELETE, 31'd3);
      issue(FUNC_INSERT, 31'd10);
      issue(FUNC_FIND, 31'd10);
      issue(FUNC_DELETE, 31'd10);
      issue(FUNC_FIND, 31'd10);
      issue(FUNC_INSERT, 31'h7FFF_FFFF);
      issue(FUNC_UNKNOWN, 31'h7FFF_FFFF);
      issue(FUNC_DELETE, 31'h7FFF_FFFF);
      issue(FUNC_UNKNOWN, 31'd0);

      // Table size below two and a zero prime: a two-slot table, step one,
      // which fills at once and forces full walks.
      settle();
      set_table(11'd1, 11'd0);
      issue(FUNC_INSERT, 31'd5);
      issue(FUNC_INSERT, 31'd6);
      issue(FUNC_INSERT, 31'd9);
      issue(FUNC_FIND, 31'd9);
      issue(FUNC_DELETE, 31'd5);

      // Table size above the depth and the largest second-prime value.
      settle();
      set_table(11'd2047, 11'd1023);
      issue(FUNC_INSERT, 31'h7FFF_FFFF);
      issue(FUNC_INSERT, 31'd0);
      issue(FUNC_FIND, 31'd1024);
      issue(FUNC_INSERT, 31'd1024);
      issue(FUNC_DELETE, 31'd0);

      // Random phases over a spread of settings.
      run_phase(11'd1021, 11'd7, 150);
      run_phase(11'd13, 11'd11, 150);
      run_phase(11'd1024, 11'd1023, 120);
      run_phase(11'd2047, 11'd0, 120);
      run_phase(CSR_W'($urandom_range(2, 40)), CSR_W'($urandom_range(0, 1023)), 150);
      run_phase(11'd5, 11'd3, 100);
      calm = 1'b1;
      run_phase(CSR_W'($urandom_range(0, 2047)), CSR_W'($urandom_range(0, 1023)), 110);

      // Drain, then watch for stray responses.
      settle();
      repeat (200) @(negedge clock);
      if (board.errors == 0) begin
         $display("double_hash_table_top verification clean");
      end else begin
         $display("double_hash_table_top verification failed");
      end
      $finish;
   end
endmodule
